[sv/shift_add_mul_restoring_div_alu_assert.svh]
// Assertion macros shared by the ALU modules.
`ifndef SHIFT_ADD_MUL_RESTORING_DIV_ALU_ASSERT_SVH
`define SHIFT_ADD_MUL_RESTORING_DIV_ALU_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sam_alu_pkg.sv]
// Types and constants for the shift-add multiply / restoring divide ALU.
`default_nettype none
package sam_alu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        t_op                   operation;
        logic [DATA_WIDTH-1:0] operand_a;
        logic [DATA_WIDTH-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result_value;
        logic [DATA_WIDTH-1:0] remainder_value;
        logic                  divide_by_zero;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic iterate;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[sv/sam_alu_dp.sv]
// Datapath: operand, accumulator and quotient registers plus the output register.
`default_nettype none
module sam_alu_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sam_alu_pkg::t_in_item i_in_item,
    input  wire sam_alu_pkg::t_cmd     i_cmd,
    output sam_alu_pkg::t_sts          o_sts,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output sam_alu_pkg::t_out_item     o_out_item
);
    import sam_alu_pkg::*;
    `include "shift_add_mul_restoring_div_alu_assert.svh"

    t_op                   r_op,  n_op;
    logic [DATA_WIDTH-1:0] r_x,   n_x;
    logic [DATA_WIDTH-1:0] r_y,   n_y;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic [DATA_WIDTH-1:0] r_q,   n_q;
    logic                  r_out_valid;
    t_out_item             r_out;
    t_out_item             res;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    // restoring divide step: carry out of the remainder forces a subtract
    always_comb begin
        shifted = {r_acc[DATA_WIDTH-2:0], r_x[DATA_WIDTH-1]};
        diff    = {r_acc[DATA_WIDTH-1], shifted} - {1'b0, r_y};
        ge      = ~diff[DATA_WIDTH];
    end

    always_comb begin
        n_op  = r_op;
        n_x   = r_x;
        n_y   = r_y;
        n_acc = r_acc;
        n_q   = r_q;
        if (i_cmd.load) begin
            n_op  = i_in_item.operation;
            n_x   = i_in_item.operand_a;
            n_y   = i_in_item.operand_b;
            n_acc = '0;
            n_q   = '0;
        end else if (i_cmd.step) begin
            case (r_op)
                OP_MUL: begin
                    if (r_y[0]) begin
                        n_acc = r_acc + r_x;
                    end
                    n_x = r_x << 1;
                    n_y = r_y >> 1;
                end
                default: begin
                    n_x   = r_x << 1;
                    n_acc = ge ? diff[DATA_WIDTH-1:0] : shifted;
                    n_q   = {r_q[DATA_WIDTH-2:0], ge};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
        r_q   <= n_q;
    end

    always_comb begin
        res = '0;
        case (r_op)
            OP_ADD: res.result_value = r_x + r_y;
            OP_SUB: res.result_value = r_x - r_y;
            OP_MUL: res.result_value = r_acc;
            OP_DIV: begin
                if (r_y == '0) begin
                    res.result_value   = '1;
                    res.divide_by_zero = 1'b1;
                end else begin
                    res.result_value    = r_q;
                    res.remainder_value = r_acc;
                end
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= res;
        end
    end

    assign o_sts.iterate  = (r_op == OP_MUL) || ((r_op == OP_DIV) && (r_y != '0));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

    `SAM_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !(r_out_valid && i_out_stall), "emit over stalled item")
    `SAM_ASSERT_NOW(a_dz_rem, i_clk, i_rst_n, r_out_valid && r_out.divide_by_zero, (r_out.remainder_value == '0) && (r_out.result_value == '1), "bad zero-divisor item")
    `SAM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid && $stable(r_out), "stalled item changed")

endmodule
`default_nettype wire

[sv/sam_alu_ctrl.sv]
// Controller: state machine and step counter sequencing the datapath.
`default_nettype none
module sam_alu_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sam_alu_pkg::t_sts i_sts,
    output sam_alu_pkg::t_cmd      o_cmd
);
    import sam_alu_pkg::*;
    `include "shift_add_mul_restoring_div_alu_assert.svh"

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic               last_step;

    assign last_step = (r_cnt == CNT_W'(DATA_WIDTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (!i_sts.iterate || last_step) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        n_cnt      = r_cnt;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                n_cnt      = '0;
            end
            ST_CALC: begin
                o_cmd.step = i_sts.iterate;
                n_cnt      = r_cnt + CNT_W'(1);
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `SAM_ASSERT_NEXT(a_emit_idle, i_clk, i_rst_n, o_cmd.emit, r_state == ST_IDLE, "no return to idle after emit")
    `SAM_ASSERT_NEXT(a_short_op, i_clk, i_rst_n, (r_state == ST_CALC) && !i_sts.iterate, r_state == ST_EMIT, "single-cycle op not emitted")
    `SAM_ASSERT_NEXT(a_load_cnt, i_clk, i_rst_n, o_cmd.load, (r_state == ST_CALC) && (r_cnt == '0), "step count not cleared on load")

endmodule
`default_nettype wire

[sv/shift_add_mul_restoring_div_alu.sv]
// Top level: 32-bit integer ALU with shift-and-add multiply and restoring divide.
// Add, subtract and divide by zero pass through accept, one compute state and
// emit; multiply and divide pass through accept, 32 iterations of the
// shift-add / shift-subtract step and emit, one bit of the multiplier or
// dividend per cycle. A stalled result holds the emit state until the output
// register frees up. One item is in work at a time; the output register lets a
// new item be accepted while the previous result still waits.
`default_nettype none
module shift_add_mul_restoring_div_alu (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire sam_alu_pkg::t_in_item i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output sam_alu_pkg::t_out_item     o_out_item
);
    import sam_alu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sam_alu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sam_alu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the shift-add multiply / restoring divide ALU.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sam_alu_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIRECTED_ROWS = 20;

    typedef struct packed {
        t_op                   op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic                  typed;
        logic [DATA_WIDTH-1:0] res;
        logic [DATA_WIDTH-1:0] rem;
        logic                  dz;
    } t_directed_row;

    // typed = 1: expected values are given in the row; otherwise predicted
    localparam t_directed_row DIRECTED_TABLE [DIRECTED_ROWS] = '{
        '{OP_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0, 1'b0},
        '{OP_ADD, 32'hffff_ffff, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0, 1'b0},
        '{OP_ADD, 32'h7fff_ffff, 32'h0000_0001, 1'b1, 32'h8000_0000, 32'h0, 1'b0},
        '{OP_SUB, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'hffff_ffff, 32'h0, 1'b0},
        '{OP_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h7fff_ffff, 32'h0, 1'b0},
        '{OP_SUB, 32'h1234_5678, 32'h9abc_def0, 1'b0, 32'h0, 32'h0, 1'b0},
        '{OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0000_0001, 32'h0, 1'b0},
        '{OP_MUL, 32'h8000_0000, 32'h0000_0002, 1'b1, 32'h0000_0000, 32'h0, 1'b0},
        '{OP_MUL, 32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000, 32'h0, 1'b0},
        '{OP_MUL, 32'h1234_5678, 32'h9abc_def0, 1'b0, 32'h0, 32'h0, 1'b0},
        '{OP_DIV, 32'h1234_5678, 32'h0000_0000, 1'b1, 32'hffff_ffff, 32'h0, 1'b1},
        '{OP_DIV, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'hffff_ffff, 32'h0, 1'b1},
        '{OP_DIV, 32'hffff_ffff, 32'h0000_0001, 1'b1, 32'hffff_ffff, 32'h0, 1'b0},
        '{OP_DIV, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0000_0001, 32'h0, 1'b0},
        '{OP_DIV, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0000, 32'h0, 1'b0},
        '{OP_DIV, 32'h0000_0007, 32'h8000_0000, 1'b1, 32'h0000_0000, 32'h7, 1'b0},
        '{OP_DIV, 32'hffff_ffff, 32'h8000_0000, 1'b1, 32'h0000_0001, 32'h7fff_ffff, 1'b0},
        '{OP_DIV, 32'hffff_ffff, 32'hffff_fffe, 1'b1, 32'h0000_0001, 32'h1, 1'b0},
        '{OP_DIV, 32'h0000_0064, 32'h0000_0007, 1'b1, 32'h0000_000e, 32'h2, 1'b0},
        '{OP_DIV, 32'h8000_0000, 32'h0000_0003, 1'b0, 32'h0, 32'h0, 1'b0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    t_out_item pending_results[$];
    bit        no_idle = 1'b0;
    int        mismatch_count = 0;
    int        results_checked = 0;
    int        zero_divisor_count = 0;
    int        op_count[4] = '{0, 0, 0, 0};

    shift_add_mul_restoring_div_alu u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_out_item alu_predict(input t_in_item item);
        t_out_item             r;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic [DATA_WIDTH-1:0] acc;
        logic [DATA_WIDTH-1:0] part;
        logic                  carry;
        a = item.operand_a;
        b = item.operand_b;
        r = '0;
        case (item.operation)
            OP_ADD: r.result_value = a + b;
            OP_SUB: r.result_value = a - b;
            OP_MUL: begin
                acc = '0;
                for (int i = 0; i < DATA_WIDTH; i++) begin
                    if (b[i]) begin
                        acc = acc + (a << i);
                    end
                end
                r.result_value = acc;
            end
            default: begin
                if (b == '0) begin
                    r.result_value   = '1;
                    r.divide_by_zero = 1'b1;
                end else begin
                    part = '0;
                    for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
                        carry = part[DATA_WIDTH-1];
                        part  = {part[DATA_WIDTH-2:0], a[i]};
                        if (carry || part >= b) begin
                            part = part - b;
                            r.result_value[i] = 1'b1;
                        end
                    end
                    r.remainder_value = part;
                end
            end
        endcase
        return r;
    endfunction

    // operand mix: corners, single set or clear bits, small values, right-shifted and full-range words
    function automatic logic [DATA_WIDTH-1:0] rand_word();
        logic [DATA_WIDTH-1:0] w;
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2: w = 32'h1 << $urandom_range(0, DATA_WIDTH - 1);
            3: w = ~(32'h1 << $urandom_range(0, DATA_WIDTH - 1));
            4: w = $urandom_range(0, 15);
            5: w = $urandom >> $urandom_range(0, DATA_WIDTH - 1);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic drive_operation(input t_in_item item, input bit typed,
                                   input t_out_item typed_res);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(typed ? typed_res : alu_predict(item));
        op_count[item.operation]++;
        if (item.operation == OP_DIV && item.operand_b == '0) begin
            zero_divisor_count++;
        end
    endtask

    // result side
    initial begin
        t_out_item want;
        int        hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                $error("unexpected result item: %h", o_out_item);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_out_item.result_value !== want.result_value) begin
                    $error("result_value: expected %h, got %h",
                           want.result_value, o_out_item.result_value);
                    mismatch_count++;
                end
                if (o_out_item.remainder_value !== want.remainder_value) begin
                    $error("remainder_value: expected %h, got %h",
                           want.remainder_value, o_out_item.remainder_value);
                    mismatch_count++;
                end
                if (o_out_item.divide_by_zero !== want.divide_by_zero) begin
                    $error("divide_by_zero: expected %b, got %b",
                           want.divide_by_zero, o_out_item.divide_by_zero);
                    mismatch_count++;
                end
            end
        end
    end

    // operand side and end of run
    initial begin
        t_in_item  item;
        t_out_item typed_res;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            item.operation            = DIRECTED_TABLE[i].op;
            item.operand_a            = DIRECTED_TABLE[i].a;
            item.operand_b            = DIRECTED_TABLE[i].b;
            typed_res.result_value    = DIRECTED_TABLE[i].res;
            typed_res.remainder_value = DIRECTED_TABLE[i].rem;
            typed_res.divide_by_zero  = DIRECTED_TABLE[i].dz;
            drive_operation(item, DIRECTED_TABLE[i].typed, typed_res);
        end

        typed_res = '0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // back-to-back stretches now and then
            if (i % 100 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            item.operation = t_op'($urandom_range(0, 3));
            item.operand_a = rand_word();
            item.operand_b = rand_word();
            drive_operation(item, 1'b0, typed_res);
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Items: %0d add, %0d sub, %0d mul, %0d div (%0d with zero divisor)",
                 op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
                 op_count[OP_DIV], zero_divisor_count);
        $display("Results checked: %0d, mismatches: %0d", results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
+incdir+sv
sv/sam_alu_pkg.sv
sv/sam_alu_dp.sv
sv/sam_alu_ctrl.sv
sv/shift_add_mul_restoring_div_alu.sv
tb/tb_top.sv
